@@ hw/rtl/dot_pkg.sv @@
// Package: shared constants, codes and control structs for the depth ordering table.
`timescale 1ns / 1ps

package dot_pkg;

    localparam int OP_W       = 2;
    localparam int ID_BITS    = 6;
    localparam int DEPTH_BITS = 16;
    localparam int KIND_W     = 3;
    localparam int LINK_W     = 7;

    localparam logic [LINK_W-1:0] NO_LINK = 7'h7F;

    localparam int DEF_DEPTH_LEVELS = 256;
    localparam int DEF_MAX_OBJECTS  = 64;

    localparam logic [OP_W-1:0] OP_RESET = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RESET_DONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ENTRY      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd5;

    typedef struct packed {
        logic              capture;
        logic              clear_meta;
        logic              bkt_top;
        logic              bkt_dec;
        logic              sweep_wr;
        logic              head_rd;
        logic              add_rd;
        logic              add_commit;
        logic              link_rd;
        logic              cur_from_link;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
    } t_dot_cmd;

    typedef struct packed {
        logic [OP_W-1:0] in_opcode;
        logic            total_zero;
        logic            bkt_zero;
        logic            add_bad;
        logic            add_dup;
        logic            slot_free;
        logic            cur_valid;
        logic            last_entry;
    } t_dot_sts;

endpackage

@@ hw/rtl/dot_in_if.sv @@
// Interface: input item channel (opcode, object, depth, flags).
`timescale 1ns / 1ps

interface dot_in_if;
    logic                                valid;
    logic                                ready;
    logic [dot_pkg::OP_W-1:0]            opcode;
    logic [dot_pkg::ID_BITS-1:0]         object_id;
    logic signed [dot_pkg::DEPTH_BITS-1:0] depth;
    logic                                alive;
    logic                                visible;

    modport source (output valid, opcode, object_id, depth, alive, visible, input ready);
    modport sink   (input valid, opcode, object_id, depth, alive, visible, output ready);
endinterface

@@ hw/rtl/dot_out_if.sv @@
// Interface: result channel (kind, object number, last flag).
`timescale 1ns / 1ps

interface dot_out_if;
    logic                          valid;
    logic                          ready;
    logic [dot_pkg::KIND_W-1:0]    kind;
    logic [dot_pkg::ID_BITS-1:0]   object_id_res;
    logic                          last;

    modport source (output valid, kind, object_id_res, last, input ready);
    modport sink   (input valid, kind, object_id_res, last, output ready);
endinterface

@@ hw/rtl/dot_ram.sv @@
// Generic single-write, single-read RAM with registered read and read enable.
`timescale 1ns / 1ps

module dot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dot_dp.sv @@
// Datapath: bucket head and link memories, presence flags, counters, result register.
`timescale 1ns / 1ps

module dot_dp #(
    parameter int DEPTH_LEVELS = dot_pkg::DEF_DEPTH_LEVELS,
    parameter int MAX_OBJECTS  = dot_pkg::DEF_MAX_OBJECTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dot_pkg::t_dot_cmd i_cmd,
    output dot_pkg::t_dot_sts o_sts,
    dot_in_if.sink            i_in,
    dot_out_if.source         o_out
);

    localparam int BKT_W = $clog2(DEPTH_LEVELS);
    localparam int ID_W  = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam logic [BKT_W-1:0] BKT_TOP = BKT_W'(DEPTH_LEVELS - 1);

    logic [dot_pkg::ID_BITS-1:0]    r_id;
    logic [dot_pkg::DEPTH_BITS-1:0] r_depth;
    logic                           r_alive;
    logic                           r_visible;
    logic [BKT_W-1:0]               r_bkt, n_bkt;
    logic [CNT_W-1:0]               r_total;
    logic [CNT_W-1:0]               r_emit;
    logic [MAX_OBJECTS-1:0]         r_present;
    logic                           r_out_valid;
    logic [dot_pkg::KIND_W-1:0]     r_kind;
    logic [dot_pkg::ID_BITS-1:0]    r_out_id;
    logic                           r_last;

    logic [dot_pkg::LINK_W-1:0] w_head_rdata;
    logic [dot_pkg::LINK_W-1:0] w_link_rdata;
    logic [dot_pkg::LINK_W-1:0] w_cur;
    logic [BKT_W-1:0]           w_head_raddr;
    logic [BKT_W-1:0]           w_head_waddr;
    logic [dot_pkg::LINK_W-1:0] w_head_wdata;
    logic                       w_slot_free;
    logic                       w_last_entry;
    logic [dot_pkg::ID_BITS-1:0] w_out_id;
    logic                       w_out_last;

    always_comb begin
        n_bkt = r_bkt;
        if (i_cmd.bkt_top) begin
            n_bkt = BKT_TOP;
        end else if (i_cmd.bkt_dec) begin
            n_bkt = r_bkt - 1'b1;
        end
    end

    assign w_cur        = i_cmd.cur_from_link ? w_link_rdata : w_head_rdata;
    assign w_slot_free  = !r_out_valid || o_out.ready;
    assign w_last_entry = (r_emit + 1'b1) == r_total;

    assign w_head_raddr = i_cmd.add_rd ? r_depth[BKT_W-1:0] : n_bkt;
    assign w_head_waddr = i_cmd.add_commit ? r_depth[BKT_W-1:0] : r_bkt;
    assign w_head_wdata = i_cmd.add_commit ? dot_pkg::LINK_W'(r_id) : dot_pkg::NO_LINK;

    dot_ram #(
        .WIDTH (dot_pkg::LINK_W),
        .DEPTH (DEPTH_LEVELS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sweep_wr || i_cmd.add_commit),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_re    (i_cmd.add_rd || i_cmd.head_rd),
        .i_raddr (w_head_raddr),
        .o_rdata (w_head_rdata)
    );

    dot_ram #(
        .WIDTH (dot_pkg::LINK_W),
        .DEPTH (MAX_OBJECTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_commit),
        .i_waddr (r_id[ID_W-1:0]),
        .i_wdata (w_head_rdata),
        .i_re    (i_cmd.link_rd),
        .i_raddr (w_cur[ID_W-1:0]),
        .o_rdata (w_link_rdata)
    );

    always_comb begin
        w_out_id   = '0;
        w_out_last = 1'b1;
        case (i_cmd.out_kind)
            dot_pkg::KIND_ENTRY: begin
                w_out_id   = w_cur[dot_pkg::ID_BITS-1:0];
                w_out_last = w_last_entry;
            end
            dot_pkg::KIND_ADDED, dot_pkg::KIND_DROPPED, dot_pkg::KIND_DUPLICATE: begin
                w_out_id = r_id;
            end
            default: begin
                w_out_id = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id      <= i_in.object_id;
            r_depth   <= i_in.depth;
            r_alive   <= i_in.alive;
            r_visible <= i_in.visible;
        end
        if (i_cmd.out_load) begin
            r_kind   <= i_cmd.out_kind;
            r_out_id <= w_out_id;
            r_last   <= w_out_last;
        end
        if (i_cmd.bkt_top) begin
            r_emit <= '0;
        end else if (i_cmd.link_rd) begin
            r_emit <= r_emit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bkt       <= BKT_TOP;
            r_total     <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bkt <= n_bkt;
            if (i_cmd.clear_meta) begin
                r_total   <= '0;
                r_present <= '0;
            end else if (i_cmd.add_commit) begin
                r_total                  <= r_total + 1'b1;
                r_present[r_id[ID_W-1:0]] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_opcode  = i_in.opcode;
    assign o_sts.total_zero = r_total == '0;
    assign o_sts.bkt_zero   = r_bkt == '0;
    assign o_sts.add_bad    = !r_alive || !r_visible || r_depth[dot_pkg::DEPTH_BITS-1]
                              || (r_depth >= dot_pkg::DEPTH_BITS'(DEPTH_LEVELS))
                              || ({1'b0, r_id} >= dot_pkg::LINK_W'(MAX_OBJECTS));
    assign o_sts.add_dup    = r_present[r_id[ID_W-1:0]];
    assign o_sts.slot_free  = w_slot_free;
    assign o_sts.cur_valid  = w_cur < dot_pkg::LINK_W'(MAX_OBJECTS);
    assign o_sts.last_entry = w_last_entry;

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.object_id_res = r_out_id;
    assign o_out.last          = r_last;

endmodule

@@ hw/rtl/dot_ctrl.sv @@
// Controller: sequences clear sweep, add and draw walk over the datapath.
`timescale 1ns / 1ps

module dot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dot_pkg::t_dot_sts i_sts,
    output dot_pkg::t_dot_cmd o_cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_RDONE = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_ALINK = 4'd5;
    localparam logic [3:0] S_EMPTY = 4'd6;
    localparam logic [3:0] S_HEAD  = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       w_accept;

    assign o_in_ready = r_state == S_IDLE;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.cur_from_link = r_state == S_LINK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_sts.in_opcode)
                        dot_pkg::OP_RESET: begin
                            o_cmd.clear_meta = 1'b1;
                            o_cmd.bkt_top    = 1'b1;
                            n_state          = S_CLR;
                        end
                        dot_pkg::OP_ADD: begin
                            n_state = S_CHK;
                        end
                        dot_pkg::OP_DRAW: begin
                            if (i_sts.total_zero) begin
                                n_state = S_EMPTY;
                            end else begin
                                o_cmd.bkt_top = 1'b1;
                                o_cmd.head_rd = 1'b1;
                                n_state       = S_HEAD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INIT, S_CLR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.bkt_zero) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_RDONE;
                end else begin
                    o_cmd.bkt_dec = 1'b1;
                end
            end
            S_RDONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = dot_pkg::KIND_RESET_DONE;
                    n_state        = S_IDLE;
                end
            end
            S_CHK: begin
                if (i_sts.add_bad) begin
                    if (i_sts.slot_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = dot_pkg::KIND_DROPPED;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.add_dup) begin
                    if (i_sts.slot_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = dot_pkg::KIND_DUPLICATE;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.add_rd = 1'b1;
                    n_state      = S_ALINK;
                end
            end
            S_ALINK: begin
                if (i_sts.slot_free) begin
                    o_cmd.add_commit = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = dot_pkg::KIND_ADDED;
                    n_state          = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = dot_pkg::KIND_EMPTY;
                    n_state        = S_IDLE;
                end
            end
            S_HEAD, S_LINK: begin
                if (!i_sts.cur_valid) begin
                    if (i_sts.bkt_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.bkt_dec = 1'b1;
                        o_cmd.head_rd = 1'b1;
                        n_state       = S_HEAD;
                    end
                end else if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = dot_pkg::KIND_ENTRY;
                    o_cmd.link_rd  = 1'b1;
                    n_state        = i_sts.last_entry ? S_IDLE : S_LINK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/depth_ordering_table_unit.sv @@
// Top level: depth ordering table, controller plus datapath.
//
//   channel  | dir | handshake          | payload
//   i_in     | in  | i_in.valid/ready   | opcode, object_id, depth, alive, visible
//   o_out    | out | o_out.valid/ready  | kind, object_id_res, last
//
// One item at a time. An add checks the item, then reads its bucket head and
// links it in; a dropped or duplicate add is answered after the check. A reset
// item sweeps the bucket head RAM, one entry a cycle. A draw walks the buckets
// from the deepest down to the shallowest occupied one, one result per object;
// an empty draw reports empty. After reset the same sweep runs with i_in.ready
// low. A result waits in an output register; a stalled o_out holds the walk.
`timescale 1ns / 1ps

module depth_ordering_table_unit #(
    parameter int DEPTH_LEVELS = dot_pkg::DEF_DEPTH_LEVELS,
    parameter int MAX_OBJECTS  = dot_pkg::DEF_MAX_OBJECTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dot_in_if.sink    i_in,
    dot_out_if.source o_out
);

    dot_pkg::t_dot_cmd w_cmd;
    dot_pkg::t_dot_sts w_sts;
    logic              w_ready;

    assign i_in.ready = w_ready;

    dot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dot_dp #(
        .DEPTH_LEVELS (DEPTH_LEVELS),
        .MAX_OBJECTS  (MAX_OBJECTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
